>>> hw/rtl/iaid_pkg.sv
// ----------------------------------------------------------------------------
// iaid_pkg: shared types and constants for the indexed array editor
// Word layouts, action and status codes, cell broadcast and read tree sizing.
// ----------------------------------------------------------------------------
package iaid_pkg;

  localparam int DEPTH    = 512;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 9;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 10;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  // read tree: fan-in per node and padded leaf row
  localparam int FAN     = 8;
  localparam int LEAF_N  = DEPTH + FAN;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [ENTRY_W-1:0]       entry_count;
  } out_word_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              go;
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } cell_bc_t;

  // number of live nodes at tree level l
  function automatic int lvl_width(input int l);
    int w;
    w = DEPTH;
    for (int k = 0; k < l; k++) begin
      w = (w + FAN - 1) / FAN;
    end
    return w;
  endfunction

  function automatic int tree_levels();
    int w;
    int n;
    w = DEPTH;
    n = 0;
    while (w > 1) begin
      w = (w + FAN - 1) / FAN;
      n = n + 1;
    end
    return (n < 1) ? 1 : n;
  endfunction

  localparam int LVLS = tree_levels();

endpackage

>>> hw/rtl/indexed_array_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_array_insert_delete: packed array editor with indexed edits
// Insert, delete, modify and read on a row of shifting cells plus a count.
// ----------------------------------------------------------------------------
//
//   channel | direction | word        | handshake
//   --------+-----------+-------------+-------------------------------
//   in      | input     | in_word_t   | in_valid / in_stall (driven here)
//   out     | output    | out_word_t  | out_valid / out_stall (from sink)
//
// A result is presented after its word is accepted and passes these steps:
// an execute step in which every cell shifts or loads in parallel while the
// first read tree level samples the addressed entry, LVLS - 1 further tree
// levels, one step to park the result and one to load the output register.
// The next word is taken only after that, once the result is in the output
// register; a new word is not accepted while one is still in progress.
// Reset clears the count, the control state and the output valid; cell
// contents come up unknown and are never read before being written.
// A stalled output holds its word; the next input word is taken once the
// result has moved into the output register, even while that register still
// waits. A second result stays parked, and the input stalls, until the output
// word is taken.
// ----------------------------------------------------------------------------
module indexed_array_insert_delete (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iaid_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output iaid_pkg::out_word_t out_word
);
  import iaid_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  in_word_t          in_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  out_word_t         res_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r;

  logic              in_acc;
  logic              out_load;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              ok;
  logic [STATUS_W-1:0] status_calc;
  cell_bc_t          bc;
  logic              tree_done;
  logic [DATA_W-1:0] tree_data;

  logic [DATA_W-1:0] cell_val [DEPTH];
  logic [DATA_W-1:0] sel_val  [DEPTH];

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // capture the word on acceptance; it is worked on from the register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_word;
    end
  end

  // range and capacity checks; index check wins over the full check
  assign pos_x = CMP_W'(in_r.position);
  assign cnt_x = CMP_W'(count_r);

  always_comb begin
    status_calc = ST_DONE;
    if (in_r.action == ACT_INSERT) begin
      if (pos_x > cnt_x) begin
        status_calc = ST_RANGE;
      end else if (count_r == CNT_W'(DEPTH)) begin
        status_calc = ST_FULL;
      end
    end else if (pos_x >= cnt_x) begin
      status_calc = ST_RANGE;
    end
  end

  assign ok = (status_calc == ST_DONE);

  // broadcast to the row; cells act only in the execute cycle
  always_comb begin
    bc.go    = (state_r == S_EXEC) && ok;
    bc.act   = in_r.action;
    bc.pos   = in_r.position;
    bc.count = count_r;
    bc.value = DATA_W'(in_r.new_value);
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;
      if (i == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_left
        assign left_v = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_right
        assign right_v = cell_val[i+1];
      end
      iaid_cell u_cell (
        .clk       (clk),
        .bc        (bc),
        .idx       (IDX_W'(i)),
        .left_val  (left_v),
        .right_val (right_v),
        .val       (cell_val[i]),
        .sel_val   (sel_val[i])
      );
    end
  endgenerate

  // the tree samples the addressed entry before the cells update
  iaid_rd_tree u_rd_tree (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_EXEC),
    .leaf    (sel_val),
    .done    (tree_done),
    .rd_data (tree_data)
  );

  assign out_load = (state_r == S_HOLD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = status_calc;
        rd_ok_nxt  = ok && (in_r.action == ACT_READ);
        if (ok && in_r.action == ACT_INSERT) begin
          count_nxt = count_r + CNT_W'(1);
        end else if (ok && in_r.action == ACT_DELETE) begin
          count_nxt = count_r - CNT_W'(1);
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (tree_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // park the finished result until the output register is free
  always_ff @(posedge clk) begin
    if (state_r == S_WAIT && tree_done) begin
      res_r.status      <= status_r;
      res_r.read_value  <= rd_ok_r ? tree_data : '0;
      res_r.entry_count <= ENTRY_W'(count_r);
    end
    if (out_load) begin
      out_r <= res_r;
    end
    status_r <= status_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

>>> hw/rtl/iaid_cell.sv
// ----------------------------------------------------------------------------
// iaid_cell: one entry of the packed array
// Holds, loads the new value, or takes a neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module iaid_cell (
  input  logic                      clk,
  input  iaid_pkg::cell_bc_t        bc,
  input  logic [iaid_pkg::IDX_W-1:0]  idx,
  input  logic [iaid_pkg::DATA_W-1:0] left_val,
  input  logic [iaid_pkg::DATA_W-1:0] right_val,
  output logic [iaid_pkg::DATA_W-1:0] val,
  output logic [iaid_pkg::DATA_W-1:0] sel_val
);
  import iaid_pkg::*;

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic [CMP_W-1:0]  ix;
  logic [CMP_W-1:0]  p;
  logic [CMP_W-1:0]  cnt;
  logic [CMP_W:0]    ix_inc;
  logic              hit;

  assign ix     = CMP_W'(idx);
  assign p      = CMP_W'(bc.pos);
  assign cnt    = CMP_W'(bc.count);
  assign ix_inc = {1'b0, ix} + (CMP_W + 1)'(1);
  assign hit    = (ix == p);

  always_comb begin
    val_nxt = val_r;
    if (bc.go) begin
      unique case (bc.act)
        ACT_INSERT: begin
          if (hit) begin
            val_nxt = bc.value;
          end else if (ix > p && ix <= cnt) begin
            val_nxt = left_val;
          end
        end
        ACT_DELETE: begin
          if (ix >= p && ix_inc < {1'b0, cnt}) begin
            val_nxt = right_val;
          end
        end
        ACT_MODIFY: begin
          if (hit) begin
            val_nxt = bc.value;
          end
        end
        default: begin
          val_nxt = val_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val     = val_r;
  assign sel_val = hit ? val_r : '0;

endmodule

>>> hw/rtl/iaid_rd_tree.sv
// ----------------------------------------------------------------------------
// iaid_rd_tree: registered OR tree that gathers the selected entry
// Only the addressed cell drives a nonzero leaf; each level ORs FAN nodes.
// ----------------------------------------------------------------------------
module iaid_rd_tree (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [iaid_pkg::DATA_W-1:0] leaf [iaid_pkg::DEPTH],
  output logic                      done,
  output logic [iaid_pkg::DATA_W-1:0] rd_data
);
  import iaid_pkg::*;

  logic [DATA_W-1:0] lv [LVLS+1][LEAF_N];
  logic [LVLS-1:0]   vld_r;
  logic [LVLS-1:0]   vld_nxt;

  genvar l, j;

  generate
    for (j = 0; j < LEAF_N; j++) begin : g_leaf
      if (j < DEPTH) begin : g_live
        assign lv[0][j] = leaf[j];
      end else begin : g_pad
        assign lv[0][j] = '0;
      end
    end

    for (l = 1; l <= LVLS; l++) begin : g_lvl
      localparam int W = lvl_width(l);
      for (j = 0; j < LEAF_N; j++) begin : g_node
        if (j < W) begin : g_live
          logic [DATA_W-1:0] acc;
          always_comb begin
            acc = '0;
            for (int k = 0; k < FAN; k++) begin
              acc = acc | lv[l-1][j*FAN + k];
            end
          end
          always_ff @(posedge clk) begin
            lv[l][j] <= acc;
          end
        end else begin : g_pad
          always_ff @(posedge clk) begin
            lv[l][j] <= '0;
          end
        end
      end
    end
  endgenerate

  // advance the valid marker one level per cycle
  assign vld_nxt = LVLS'({vld_r, start});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign done    = vld_r[LVLS-1];
  assign rd_data = lv[LVLS][0];

endmodule
